// File: design/pspf_pkg.sv
// Package for the pen stroke point filter: field widths, parameter defaults,
// register indexes and the command/status words between controller and datapath.
// No dependencies.
package pspf_pkg;

   localparam int FRAC_BITS_DEF  = 4;
   localparam int MAX_CANVAS_DEF = 8192;

   localparam int POS_W      = 19;
   localparam int PT_W       = 18;
   localparam int CANVAS_W   = 14;
   localparam int FOLLOW_W   = 9;
   localparam int SPACING_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLLOW_Q8     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPACING   = 3'd3;

   localparam logic [CANVAS_W-1:0]  CANVAS_WIDTH_RST  = 14'd1920;
   localparam logic [CANVAS_W-1:0]  CANVAS_HEIGHT_RST = 14'd1080;
   localparam logic [FOLLOW_W-1:0]  FOLLOW_RST        = 9'd256;
   localparam logic [FOLLOW_W-1:0]  FOLLOW_MAX        = 9'd256;
   localparam logic [SPACING_W-1:0] SPACING_RST       = 16'd8;

   typedef struct packed {
      logic load_in;   // capture and clamp a new input word
      logic calc;      // run the follow step
      logic load_out;  // emit the point and make it the last point
   } pspf_cmd_type;

   typedef struct packed {
      logic emit_ok;   // current sample produces a point
   } pspf_status_type;

endpackage

// File: design/pen_stroke_point_filter.sv
// Top level of the pen stroke point filter: joins controller and datapath.
// Depends on pspf_pkg, pspf_ctrl and pspf_dp.
//
//   channel   direction  handshake              word
//   req_      in         req_valid / req_stall  pos_x, pos_y, stroke_begin
//   rsp_      out        rsp_valid / rsp_stall  point_x, point_y, first_of_stroke
//   csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// A sample passes the follow multiply in state LERP, then the squared distance
// test in state DIST; the next sample is taken in the test state, so a new word
// can be accepted before the last one is done. A point that finds the output
// register full holds the test state until rsp_stall drops. Reset loads the
// register defaults and forgets the last point. csr_ready is always high.
module pen_stroke_point_filter
   import pspf_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int MAX_CANVAS = MAX_CANVAS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic                  req_stroke_begin,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PT_W-1:0]       rsp_point_x,
   output logic [PT_W-1:0]       rsp_point_y,
   output logic                  rsp_first_of_stroke,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   pspf_cmd_type    cmd;
   pspf_status_type status;

   assign csr_ready = 1'b1;

   pspf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pspf_dp #(
      .FRAC_BITS  (FRAC_BITS),
      .MAX_CANVAS (MAX_CANVAS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_stroke_begin    (req_stroke_begin),
      .rsp_point_x         (rsp_point_x),
      .rsp_point_y         (rsp_point_y),
      .rsp_first_of_stroke (rsp_first_of_stroke),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

// File: design/pspf_ctrl.sv
// Controller of the pen stroke point filter: sequences accept, follow step and
// spacing test, and owns the result valid flag. Depends on pspf_pkg.
module pspf_ctrl
   import pspf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  pspf_status_type status,
   output pspf_cmd_type    cmd
);

   typedef enum logic [1:0] {IDLE, LERP, DIST} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free, done, accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign done      = (state_ff == DIST) && (!status.emit_ok || out_free);
   assign req_stall = !((state_ff == IDLE) || done);
   assign accept    = req_valid && !req_stall;

   assign cmd.load_in  = accept;
   assign cmd.calc     = (state_ff == LERP);
   assign cmd.load_out = (state_ff == DIST) && status.emit_ok && out_free;

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: if (accept) state_in = LERP;
         LERP: state_in = DIST;
         DIST: begin
            // hold while the point waits for the output register
            if (done) state_in = accept ? LERP : IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/pspf_dp.sv
// Datapath of the pen stroke point filter: registers, clamp, follow step,
// squared distance test, last point and output word. Depends on pspf_pkg.
module pspf_dp
   import pspf_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int MAX_CANVAS = MAX_CANVAS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic                  req_stroke_begin,
   output logic [PT_W-1:0]       rsp_point_x,
   output logic [PT_W-1:0]       rsp_point_y,
   output logic                  rsp_first_of_stroke,
   input  pspf_cmd_type          cmd,
   output pspf_status_type       status
);

   localparam int HI_W   = CANVAS_W + FRAC_BITS;
   localparam int CMP_W  = (HI_W > PT_W ? HI_W : PT_W) + 1;
   localparam int MAX_W  = 18;
   localparam int HALF   = (1 << FRAC_BITS) >> 1;
   localparam int PROD_W = POS_W + FOLLOW_W + 1;
   localparam int SQ_W   = 2 * POS_W;

   // configuration registers
   logic [CANVAS_W-1:0]  width_ff, height_ff;
   logic [FOLLOW_W-1:0]  follow_ff;
   logic [SPACING_W-1:0] spacing_ff;

   logic [PT_W-1:0]        px_ff, py_ff, last_x_ff, last_y_ff, fx_ff, fy_ff;
   logic [PT_W-1:0]        px_in, py_in, fx_in, fy_in;
   logic                   begin_ff, have_point_ff;
   logic signed [POS_W-1:0] step_x_ff, step_y_ff, step_x_in, step_y_in;
   logic [2*SPACING_W-1:0] min2_ff, min2_in;
   logic [PT_W-1:0]        out_x_ff, out_y_ff;
   logic                   out_first_ff;

   function automatic logic [PT_W-1:0] clamp_axis(input logic [POS_W-1:0] v,
                                                  input logic [CANVAS_W-1:0] size);
      logic [CANVAS_W-1:0] s;
      logic [HI_W-1:0]     hi;
      logic [PT_W-1:0]     res;
      s = size;
      if (size == '0) s = CANVAS_W'(1);
      else if (MAX_W'(size) > MAX_W'(MAX_CANVAS)) s = CANVAS_W'(MAX_CANVAS);
      hi = HI_W'(s) << FRAC_BITS;
      if (v[POS_W-1]) res = '0;
      else if (CMP_W'(v[PT_W-1:0]) > CMP_W'(hi)) res = PT_W'(hi);
      else res = v[PT_W-1:0];
      return res;
   endfunction

   function automatic logic signed [POS_W-1:0] follow_step(input logic [PT_W-1:0] p,
                                                           input logic [PT_W-1:0] last,
                                                           input logic [FOLLOW_W-1:0] f);
      logic signed [POS_W-1:0]  d;
      logic signed [PROD_W-1:0] t;
      d = $signed({1'b0, p}) - $signed({1'b0, last});
      t = PROD_W'(d) * PROD_W'($signed({1'b0, f})) + PROD_W'(128);
      return t[POS_W+7:8];   // floor of t / 256
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= CANVAS_WIDTH_RST;
         height_ff  <= CANVAS_HEIGHT_RST;
         follow_ff  <= FOLLOW_RST;
         spacing_ff <= SPACING_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH:  width_ff   <= csr_data[CANVAS_W-1:0];
            CSR_CANVAS_HEIGHT: height_ff  <= csr_data[CANVAS_W-1:0];
            CSR_FOLLOW_Q8:     follow_ff  <= csr_data[FOLLOW_W-1:0];
            CSR_MIN_SPACING:   spacing_ff <= csr_data[SPACING_W-1:0];
            default: ;
         endcase
      end
   end

   assign px_in = clamp_axis(req_pos_x, width_ff);
   assign py_in = clamp_axis(req_pos_y, height_ff);

   // follow step and squared spacing
   always_comb begin
      logic [FOLLOW_W-1:0]  f;
      logic [SPACING_W-1:0] s;
      f = (follow_ff > FOLLOW_MAX) ? FOLLOW_MAX : follow_ff;
      s = (spacing_ff < SPACING_W'(HALF)) ? SPACING_W'(HALF) : spacing_ff;
      step_x_in = follow_step(px_ff, last_x_ff, f);
      step_y_in = follow_step(py_ff, last_y_ff, f);
      fx_in = begin_ff ? px_ff
                       : PT_W'($signed({1'b0, last_x_ff}) + step_x_in);
      fy_in = begin_ff ? py_ff
                       : PT_W'($signed({1'b0, last_y_ff}) + step_y_in);
      min2_in = (2*SPACING_W)'(s) * (2*SPACING_W)'(s);
   end

   // spacing test
   always_comb begin
      logic signed [SQ_W-1:0] sq_x, sq_y;
      logic [SQ_W:0]          dist2;
      sq_x  = SQ_W'(step_x_ff) * SQ_W'(step_x_ff);
      sq_y  = SQ_W'(step_y_ff) * SQ_W'(step_y_ff);
      dist2 = (SQ_W+1)'($unsigned(sq_x)) + (SQ_W+1)'($unsigned(sq_y));
      status.emit_ok = begin_ff
                    || (have_point_ff && (dist2 >= (SQ_W+1)'(min2_ff)));
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         begin_ff <= req_stroke_begin;
      end
      if (cmd.calc) begin
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
         fx_ff     <= fx_in;
         fy_ff     <= fy_in;
         min2_ff   <= min2_in;
      end
      if (cmd.load_out) begin
         last_x_ff    <= fx_ff;
         last_y_ff    <= fy_ff;
         out_x_ff     <= fx_ff;
         out_y_ff     <= fy_ff;
         out_first_ff <= begin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_point_ff <= 1'b0;
      end else if (cmd.load_out) begin
         have_point_ff <= 1'b1;
      end
   end

   assign rsp_point_x         = out_x_ff;
   assign rsp_point_y         = out_y_ff;
   assign rsp_first_of_stroke = out_first_ff;

endmodule
